// ===== src/isp_pkg.sv =====
// Package with widths, character codes, parser states and shared types.
`timescale 1ns / 1ps

package isp_pkg;

  // Field widths.
  localparam int CH_W    = 8;
  localparam int VAL_W   = 64;
  localparam int STAT_W  = 2;
  localparam int STATE_W = 3;
  localparam int DIG_W   = 4;

  // Character codes.
  localparam logic [CH_W-1:0] CHAR_0     = 8'h30;
  localparam logic [CH_W-1:0] CHAR_9     = 8'h39;
  localparam logic [CH_W-1:0] CHAR_A     = 8'h61;
  localparam logic [CH_W-1:0] CHAR_F     = 8'h66;
  localparam logic [CH_W-1:0] CHAR_X     = 8'h78;
  localparam logic [CH_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CH_W-1:0] CHAR_SPACE = 8'h20;

  // Largest accumulator that can still take one more decimal digit.
  localparam logic [VAL_W-1:0] DEC_LIMIT = 64'h1999999999999999;

  // Parser states.
  localparam logic [STATE_W-1:0] ST_START  = 3'd0;
  localparam logic [STATE_W-1:0] ST_ZERO   = 3'd1;
  localparam logic [STATE_W-1:0] ST_DEC    = 3'd2;
  localparam logic [STATE_W-1:0] ST_NEG    = 3'd3;
  localparam logic [STATE_W-1:0] ST_HEXPRE = 3'd4;
  localparam logic [STATE_W-1:0] ST_HEX    = 3'd5;
  localparam logic [STATE_W-1:0] ST_TRAIL  = 3'd6;
  localparam logic [STATE_W-1:0] ST_ERR    = 3'd7;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UOVF = 2'd2;
  localparam logic [STAT_W-1:0] STAT_SOVF = 2'd3;

  // One registered input character.
  typedef struct packed {
    logic            valid;
    logic [CH_W-1:0] ch;
    logic            last;
  } isp_item_t;

  // Raw end-of-string result before sign handling.
  typedef struct packed {
    logic              valid;
    logic              err;
    logic [STAT_W-1:0] code;
    logic              negative;
    logic [VAL_W-1:0]  accum;
  } isp_raw_t;

endpackage

// ===== src/isp_in_if.sv =====
// Character channel interface: valid, ready and one character with its last mark.
`timescale 1ns / 1ps

interface isp_in_if;
  logic                    valid;
  logic                    ready;
  logic [isp_pkg::CH_W-1:0] ch;
  logic                    last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

// ===== src/isp_out_if.sv =====
// Result channel interface: valid, ready, parsed value and status.
`timescale 1ns / 1ps

interface isp_out_if;
  logic                        valid;
  logic                        ready;
  logic [isp_pkg::VAL_W-1:0]  value;
  logic [isp_pkg::STAT_W-1:0] status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== src/isp_in_stage.sv =====
// Input register stage that captures one character per transfer.
`timescale 1ns / 1ps

module isp_in_stage (
  input  logic               clk,
  input  logic               rst,
  isp_in_if.sink             in_ch,
  input  logic               take,
  output isp_pkg::isp_item_t item
);
  import isp_pkg::*;

  isp_item_t held;

  // The register may load whenever it is empty or its item leaves this cycle.
  assign in_ch.ready = !held.valid || take;
  assign item        = held;

  // Capture the character and its last mark.
  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      held.valid <= 1'b1;
      held.ch    <= in_ch.ch;
      held.last  <= in_ch.last;
    end else if (take) begin
      held.valid <= 1'b0;
    end
  end

endmodule

// ===== src/isp_parser.sv =====
// Parser automaton: per-character state update and raw end-of-string result register.
`timescale 1ns / 1ps

module isp_parser (
  input  logic               clk,
  input  logic               rst,
  input  isp_pkg::isp_item_t item,
  input  logic               raw_adv,
  output logic               take,
  output isp_pkg::isp_raw_t  raw
);
  import isp_pkg::*;

  logic [STATE_W-1:0] pstate;
  logic [STATE_W-1:0] pstate_next;
  logic [VAL_W-1:0]   accum;
  logic [VAL_W-1:0]   accum_next;
  logic               negative;
  logic               negative_next;
  logic [STAT_W-1:0]  err_code;
  logic [STAT_W-1:0]  err_code_next;
  isp_raw_t           raw_q;

  logic               is_dig;
  logic               is_hexl;
  logic [DIG_W-1:0]   dig_val;
  logic [DIG_W-1:0]   hex_val;
  logic               dec_ovf;
  logic               hex_ovf;
  logic [VAL_W-1:0]   dec_acc;
  logic [VAL_W-1:0]   hex_acc;
  logic               raw_free;

  // Character classes and digit values.
  assign is_dig  = (item.ch >= CHAR_0) && (item.ch <= CHAR_9);
  assign is_hexl = (item.ch >= CHAR_A) && (item.ch <= CHAR_F);
  assign dig_val = item.ch[DIG_W-1:0];
  assign hex_val = item.ch[DIG_W-1:0] + 4'd9;

  // Decimal step: accum * 10 + digit, with an exact unsigned overflow check.
  assign dec_acc = {accum[VAL_W-4:0], 3'b000} + {accum[VAL_W-2:0], 1'b0}
                 + {{(VAL_W-DIG_W){1'b0}}, dig_val};
  assign dec_ovf = (accum > DEC_LIMIT) || ((accum == DEC_LIMIT) && (dig_val > 4'd5));

  // Hex step: shift in one nibble; any set bit in the top nibble overflows.
  assign hex_acc = {accum[VAL_W-DIG_W-1:0], (is_dig ? dig_val : hex_val)};
  assign hex_ovf = (accum[VAL_W-1:VAL_W-DIG_W] != '0);

  // An item leaves the input register unless it ends a string and the raw slot is busy.
  assign raw_free = !raw_q.valid || raw_adv;
  assign take     = item.valid && (!item.last || raw_free);
  assign raw      = raw_q;

  // Next state of the automaton for the current character.
  always_comb begin
    pstate_next   = pstate;
    accum_next    = accum;
    negative_next = negative;
    err_code_next = err_code;
    unique case (pstate) inside
      ST_START: begin
        if (is_dig) begin
          accum_next  = {{(VAL_W-DIG_W){1'b0}}, dig_val};
          pstate_next = (item.ch == CHAR_0) ? ST_ZERO : ST_DEC;
        end else if (item.ch == CHAR_MINUS) begin
          negative_next = 1'b1;
          pstate_next   = ST_NEG;
        end else if (item.ch != CHAR_SPACE) begin
          pstate_next   = ST_ERR;
          err_code_next = STAT_BAD;
        end
      end
      ST_NEG: begin
        if (is_dig) begin
          accum_next  = {{(VAL_W-DIG_W){1'b0}}, dig_val};
          pstate_next = (item.ch == CHAR_0) ? ST_ZERO : ST_DEC;
        end else begin
          pstate_next   = ST_ERR;
          err_code_next = STAT_BAD;
        end
      end
      ST_ZERO: begin
        if (is_dig) begin
          accum_next  = {{(VAL_W-DIG_W){1'b0}}, dig_val};
          pstate_next = ST_DEC;
        end else if (item.ch == CHAR_X) begin
          pstate_next = ST_HEXPRE;
        end else if (item.ch == CHAR_SPACE) begin
          pstate_next = ST_TRAIL;
        end else begin
          pstate_next   = ST_ERR;
          err_code_next = STAT_BAD;
        end
      end
      ST_DEC: begin
        if (is_dig) begin
          if (dec_ovf) begin
            pstate_next   = ST_ERR;
            err_code_next = STAT_UOVF;
          end else begin
            accum_next  = dec_acc;
            pstate_next = ST_DEC;
          end
        end else if (item.ch == CHAR_SPACE) begin
          pstate_next = ST_TRAIL;
        end else begin
          pstate_next   = ST_ERR;
          err_code_next = STAT_BAD;
        end
      end
      ST_HEXPRE, ST_HEX: begin
        if (is_dig || is_hexl) begin
          if (hex_ovf) begin
            pstate_next   = ST_ERR;
            err_code_next = STAT_UOVF;
          end else begin
            accum_next  = hex_acc;
            pstate_next = ST_HEX;
          end
        end else begin
          pstate_next   = ST_ERR;
          err_code_next = STAT_BAD;
        end
      end
      ST_TRAIL: begin
        if (item.ch != CHAR_SPACE) begin
          pstate_next   = ST_ERR;
          err_code_next = STAT_BAD;
        end
      end
      default: begin
        // The error state swallows characters until the end of the string.
        pstate_next = ST_ERR;
      end
    endcase
  end

  // Parser state; the end of a string returns it to the start state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pstate   <= ST_START;
      accum    <= '0;
      negative <= 1'b0;
      err_code <= STAT_OK;
    end else if (take) begin
      if (item.last) begin
        pstate   <= ST_START;
        accum    <= '0;
        negative <= 1'b0;
        err_code <= STAT_OK;
      end else begin
        pstate   <= pstate_next;
        accum    <= accum_next;
        negative <= negative_next;
        err_code <= err_code_next;
      end
    end
  end

  // Raw result slot, loaded by the last character of a string.
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_q.valid <= 1'b0;
    end else if (take && item.last) begin
      raw_q.valid    <= 1'b1;
      raw_q.err      <= (pstate_next == ST_ERR);
      raw_q.code     <= (err_code_next == STAT_OK) ? STAT_BAD : err_code_next;
      raw_q.negative <= negative_next;
      raw_q.accum    <= accum_next;
    end else if (raw_adv) begin
      raw_q.valid <= 1'b0;
    end
  end

endmodule

// ===== src/isp_out_stage.sv =====
// Output stage: sign handling, status selection and the result register.
`timescale 1ns / 1ps

module isp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  isp_pkg::isp_raw_t raw,
  output logic              raw_adv,
  isp_out_if.source         res
);
  import isp_pkg::*;

  logic               out_valid;
  logic [VAL_W-1:0]   out_value;
  logic [STAT_W-1:0]  out_status;
  logic [STAT_W-1:0]  fmt_status;
  logic [VAL_W-1:0]   fmt_value;

  // The raw result moves on when the output register is empty or being drained.
  assign raw_adv = raw.valid && (!out_valid || res.ready);

  // A negative magnitude with the top bit set is reported as a signed overflow.
  always_comb begin
    if (raw.err) begin
      fmt_status = raw.code;
    end else if (raw.negative && raw.accum[VAL_W-1]) begin
      fmt_status = STAT_SOVF;
    end else begin
      fmt_status = STAT_OK;
    end
    if (fmt_status != STAT_OK) begin
      fmt_value = '0;
    end else if (raw.negative) begin
      fmt_value = '0 - raw.accum;
    end else begin
      fmt_value = raw.accum;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (raw_adv) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (raw_adv) begin
      out_value  <= fmt_value;
      out_status <= fmt_status;
    end
  end

  assign res.valid  = out_valid;
  assign res.value  = out_value;
  assign res.status = out_status;

endmodule

// ===== src/integer_string_parser_core.sv =====
// Top level of the streaming ASCII decimal and hex integer parser.
//
//   Channel  Role    Payload                 Per transfer
//   in_ch    sink    ch[7:0], last           one character of a string
//   res      source  value[63:0], status[1:0] one result per string, on last
//
// One character is taken every cycle, unless a last character waits for a busy raw
// result slot; the automaton step is one decimal multiply-add by ten and a 64-bit
// limit compare between registers. A result passes the input register, the parser's
// raw result slot, then sign handling into the output register. Reset (rst,
// synchronous) returns the parser to its start state and empties all stages. A
// stalled result keeps its slot and the raw slot; characters that do not end a
// string keep flowing meanwhile.
`timescale 1ns / 1ps

module integer_string_parser_core (
  input  logic      clk,
  input  logic      rst,
  isp_in_if.sink    in_ch,
  isp_out_if.source res
);
  import isp_pkg::*;

  isp_item_t item;
  isp_raw_t  raw;
  logic      take;
  logic      raw_adv;

  // Input register.
  isp_in_stage u_in (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .take  (take),
    .item  (item)
  );

  // Parser automaton.
  isp_parser u_parse (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .raw_adv (raw_adv),
    .take    (take),
    .raw     (raw)
  );

  // Sign handling and result register.
  isp_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .raw     (raw),
    .raw_adv (raw_adv),
    .res     (res)
  );

`ifndef SYNTHESIS
  // A failed parse never carries a value.
  a_err_value_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.status != STAT_OK) |-> (res.value == '0))
    else $error("nonzero value with error status");

  // A new raw result only follows the last character of a string.
  a_raw_from_last: assert property (@(posedge clk) disable iff (rst)
    raw.valid && !$past(raw.valid && !raw_adv) |-> $past(take && item.last))
    else $error("raw result without a last character");

  // Reset leaves no result on the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !res.valid)
    else $error("result valid right after reset");
`endif

endmodule

// ===== verif/integer_string_parser_core_tb.sv =====
// Self-checking testbench for the streaming ASCII integer parser core.
`timescale 1ns / 1ps

module integer_string_parser_core_tb;
  import isp_pkg::*;

  localparam int RANDOM_CHARS = 650;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
  } char_xfer_t;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [STAT_W-1:0] status;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  isp_in_if  in_ch ();
  isp_out_if res ();

  integer_string_parser_core i_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .res   (res)
  );

  // Stimulus and expectation stores.
  char_xfer_t    char_q[$];
  parse_result_t due_results[$];

  // Shadow copy of the parser state.
  logic [STATE_W-1:0] sh_state;
  logic [VAL_W-1:0]   sh_accum;
  logic               sh_negative;
  logic [STAT_W-1:0]  sh_err;

  int total_chars;
  int chars_taken;
  int strings_done;
  int results_checked;
  int error_count;
  int cycle_count;
  int status_seen[4];

  char_xfer_t    next_char;
  parse_result_t got_result;
  parse_result_t want_result;

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle percentage for each side, by how far through the stimulus the run is.
  function automatic int idle_pct(input bit sender);
    int phase;
    phase = (total_chars == 0) ? 0 : (3 * chars_taken) / total_chars;
    if (phase == 0) return sender ? 33 : 53;
    if (phase == 1) return sender ? 53 : 33;
    return 0;
  endfunction

  function automatic void clear_parser();
    sh_state    = ST_START;
    sh_accum    = '0;
    sh_negative = 1'b0;
    sh_err      = STAT_OK;
  endfunction

  function automatic void parse_fail(input logic [STAT_W-1:0] code);
    sh_state = ST_ERR;
    sh_err   = code;
  endfunction

  // Advance the shadow automaton by one character.
  function automatic void advance_parser(input logic [CH_W-1:0] c);
    logic            is_dig;
    logic            is_hex;
    logic [DIG_W-1:0] dv;
    is_dig = (c >= CHAR_0) && (c <= CHAR_9);
    is_hex = (c >= CHAR_A) && (c <= CHAR_F);
    dv     = is_dig ? DIG_W'(c - CHAR_0) : (is_hex ? DIG_W'(c - CHAR_A + 8'd10) : '0);
    case (sh_state)
      ST_START, ST_NEG: begin
        if (c == CHAR_0) begin
          sh_accum = '0;
          sh_state = ST_ZERO;
        end else if (is_dig) begin
          sh_accum = VAL_W'(dv);
          sh_state = ST_DEC;
        end else if (sh_state == ST_START && c == CHAR_MINUS) begin
          sh_negative = 1'b1;
          sh_state    = ST_NEG;
        end else if (!(sh_state == ST_START && c == CHAR_SPACE)) begin
          parse_fail(STAT_BAD);
        end
      end
      ST_ZERO: begin
        if (is_dig) begin
          sh_accum = VAL_W'(dv);
          sh_state = ST_DEC;
        end else if (c == CHAR_X) begin
          sh_state = ST_HEXPRE;
        end else if (c == CHAR_SPACE) begin
          sh_state = ST_TRAIL;
        end else begin
          parse_fail(STAT_BAD);
        end
      end
      ST_DEC: begin
        if (is_dig) begin
          // Exact unsigned overflow check before the multiply-add.
          if (sh_accum > DEC_LIMIT || (sh_accum == DEC_LIMIT && dv > 4'd5)) begin
            parse_fail(STAT_UOVF);
          end else begin
            sh_accum = sh_accum * 64'd10 + VAL_W'(dv);
          end
        end else if (c == CHAR_SPACE) begin
          sh_state = ST_TRAIL;
        end else begin
          parse_fail(STAT_BAD);
        end
      end
      ST_HEXPRE, ST_HEX: begin
        if (is_dig || is_hex) begin
          if (sh_accum[VAL_W-1:VAL_W-4] != '0) begin
            parse_fail(STAT_UOVF);
          end else begin
            sh_accum = {sh_accum[VAL_W-5:0], dv};
            sh_state = ST_HEX;
          end
        end else begin
          parse_fail(STAT_BAD);
        end
      end
      ST_TRAIL: begin
        if (c != CHAR_SPACE) parse_fail(STAT_BAD);
      end
      default: begin
        sh_state = ST_ERR;
      end
    endcase
  endfunction

  // Account for one accepted character; on last, queue the expected result.
  function automatic void parse_char(input logic [CH_W-1:0] c, input logic is_last);
    parse_result_t r;
    if (sh_state != ST_ERR) advance_parser(c);
    if (!is_last) return;
    r.value = '0;
    if (sh_state == ST_ERR) begin
      r.status = (sh_err == STAT_OK) ? STAT_BAD : sh_err;
    end else if (sh_negative && sh_accum[VAL_W-1]) begin
      r.status = STAT_SOVF;
    end else begin
      r.status = STAT_OK;
      r.value  = sh_negative ? (~sh_accum + 64'd1) : sh_accum;
    end
    due_results.push_back(r);
    status_seen[r.status]++;
    strings_done++;
    clear_parser();
  endfunction

  // Character driver: holds each transfer until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.ch    <= '0;
      in_ch.last  <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        parse_char(in_ch.ch, in_ch.last);
        chars_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (char_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          next_char = char_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.ch    <= next_char.ch;
          in_ch.last  <= next_char.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        got_result.value  = res.value;
        got_result.status = res.status;
        if (due_results.size() == 0) begin
          $error("result transfer with none expected: value=%h status=%0d",
                 got_result.value, got_result.status);
          error_count++;
        end else begin
          want_result = due_results.pop_front();
          if (got_result.value !== want_result.value) begin
            $error("value mismatch: expected %h, actual %h",
                   want_result.value, got_result.value);
            error_count++;
          end
          if (got_result.status !== want_result.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   want_result.status, got_result.status);
            error_count++;
          end
          results_checked++;
        end
      end
      res.ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("integer_string_parser_core regression: fail");
      $finish;
    end
  end

  task automatic push_char(input logic [CH_W-1:0] c, input logic is_last);
    char_xfer_t x;
    x.ch   = c;
    x.last = is_last;
    char_q.push_back(x);
  endtask

  task automatic push_string(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  // Random magnitude with a random bit length, so small and huge values both appear.
  function automatic logic [VAL_W-1:0] rand_magnitude();
    int               w;
    logic [VAL_W-1:0] v;
    w = $urandom_range(64, 1);
    v = {$urandom, $urandom};
    if (w < 64) v = v & ((64'd1 << w) - 64'd1);
    return v;
  endfunction

  // Build a well-formed number string, sometimes past the overflow limit.
  function automatic string make_number();
    string s;
    string body;
    int    pick;
    s = "";
    repeat ($urandom_range(3) == 0 ? $urandom_range(3, 1) : 0) s = {s, " "};
    if ($urandom_range(99) < 35) s = {s, "-"};
    if ($urandom_range(99) < 55) begin
      pick = $urandom_range(99);
      case (pick % 8)
        0: body = "18446744073709551615";
        1: body = "18446744073709551616";
        2: body = "9223372036854775807";
        3: body = "9223372036854775808";
        4: body = "99999999999999999999";
        default: body = $sformatf("%0d", rand_magnitude());
      endcase
      if (pick >= 20) body = $sformatf("%0d", rand_magnitude());
      if ($urandom_range(9) == 0) body = {body, $sformatf("%0d", $urandom_range(9))};
      if ($urandom_range(4) == 0) body = {"0", body};
      s = {s, body};
      repeat ($urandom_range(3) == 0 ? $urandom_range(2, 1) : 0) s = {s, " "};
    end else begin
      pick = $urandom_range(99);
      case (pick % 4)
        0: body = "ffffffffffffffff";
        1: body = "10000000000000000";
        2: body = "8000000000000000";
        default: body = "7fffffffffffffff";
      endcase
      if (pick >= 16) body = $sformatf("%0h", rand_magnitude());
      if ($urandom_range(9) == 0) body = {body, $sformatf("%0h", $urandom_range(15))};
      if ($urandom_range(4) == 0) body = {"0", body};
      s = {s, "0x", body};
    end
    return s;
  endfunction

  task automatic fill_stimulus();
    string s;
    int    kind;
    int    pos;
    int    n;
    // Directed strings: lone prefixes, bad characters, extremes of the byte.
    push_string("0");
    push_string("-");
    push_string("0x");
    push_string("  ");
    push_string("9 ");
    push_string("- ");
    push_string("0xF");
    push_string("X");
    push_string("0xa ");
    push_string("-0x");
    push_string("0f");
    push_char(8'h00, 1'b1);
    push_char(8'hff, 1'b1);
    // Random strings, mostly well formed.
    while (char_q.size() < RANDOM_CHARS) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        push_string(make_number());
      end else if (kind < 70) begin
        case ($urandom_range(3))
          0: push_string("-");
          1: push_string("0x");
          2: push_string("-0x");
          default: push_string("   ");
        endcase
      end else if (kind < 85) begin
        // One character of a good string replaced by any byte.
        s   = make_number();
        pos = $urandom_range(s.len() - 1);
        for (int i = 0; i < s.len(); i++) begin
          push_char((i == pos) ? CH_W'($urandom) : CH_W'(s[i]), i == s.len() - 1);
        end
      end else begin
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++) push_char(CH_W'($urandom), i == n - 1);
      end
    end
    total_chars = char_q.size();
  endtask

  // Sequence: reset, stimulus, drain, verdict.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.ch    = '0;
    in_ch.last  = 1'b0;
    res.ready   = 1'b0;
    cycle_count = 0;
    chars_taken = 0;
    total_chars = 0;
    error_count = 0;
    clear_parser();
    fill_stimulus();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (chars_taken < total_chars) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d characters in %0d strings sent, %0d results checked",
             chars_taken, strings_done, results_checked);
    $display("status mix: ok %0d, bad char %0d, unsigned ovf %0d, signed ovf %0d",
             status_seen[STAT_OK], status_seen[STAT_BAD],
             status_seen[STAT_UOVF], status_seen[STAT_SOVF]);
    if (error_count == 0) begin
      $display("integer_string_parser_core regression: pass");
    end else begin
      $display("integer_string_parser_core regression: fail");
    end
    $finish;
  end

endmodule
